// ===== design/sha_pkg.sv =====
// shared types, constants and round functions of the sha-256 digest block
package sha_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int HASH_WORDS   = 8;
    localparam int ROUNDS       = 64;
    localparam int POS_W        = 6;
    localparam int RND_W        = 6;
    localparam int IDX_W        = 3;
    localparam int LEN_W        = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [WORD_W-1:0] t_word;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             put_byte;
        logic             pad;
        logic             len;
        logic             clr_all;
        logic             load_v;
        logic             round;
        logic [RND_W-1:0] rnd;
        logic             add_hash;
        logic             finish;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             out_busy;
    } t_dp_sts;

    // initial hash value
    function automatic t_word iv_word(input logic [IDX_W-1:0] idx);
        t_word w;
        unique case (idx)
            3'd0: w = 32'h6a09e667;
            3'd1: w = 32'hbb67ae85;
            3'd2: w = 32'h3c6ef372;
            3'd3: w = 32'ha54ff53a;
            3'd4: w = 32'h510e527f;
            3'd5: w = 32'h9b05688c;
            3'd6: w = 32'h1f83d9ab;
            default: w = 32'h5be0cd19;
        endcase
        return w;
    endfunction

    // round constants
    function automatic t_word k_word(input logic [RND_W-1:0] r);
        t_word w;
        unique case (r)
            6'd0:  w = 32'h428a2f98; 6'd1:  w = 32'h71374491;
            6'd2:  w = 32'hb5c0fbcf; 6'd3:  w = 32'he9b5dba5;
            6'd4:  w = 32'h3956c25b; 6'd5:  w = 32'h59f111f1;
            6'd6:  w = 32'h923f82a4; 6'd7:  w = 32'hab1c5ed5;
            6'd8:  w = 32'hd807aa98; 6'd9:  w = 32'h12835b01;
            6'd10: w = 32'h243185be; 6'd11: w = 32'h550c7dc3;
            6'd12: w = 32'h72be5d74; 6'd13: w = 32'h80deb1fe;
            6'd14: w = 32'h9bdc06a7; 6'd15: w = 32'hc19bf174;
            6'd16: w = 32'he49b69c1; 6'd17: w = 32'hefbe4786;
            6'd18: w = 32'h0fc19dc6; 6'd19: w = 32'h240ca1cc;
            6'd20: w = 32'h2de92c6f; 6'd21: w = 32'h4a7484aa;
            6'd22: w = 32'h5cb0a9dc; 6'd23: w = 32'h76f988da;
            6'd24: w = 32'h983e5152; 6'd25: w = 32'ha831c66d;
            6'd26: w = 32'hb00327c8; 6'd27: w = 32'hbf597fc7;
            6'd28: w = 32'hc6e00bf3; 6'd29: w = 32'hd5a79147;
            6'd30: w = 32'h06ca6351; 6'd31: w = 32'h14292967;
            6'd32: w = 32'h27b70a85; 6'd33: w = 32'h2e1b2138;
            6'd34: w = 32'h4d2c6dfc; 6'd35: w = 32'h53380d13;
            6'd36: w = 32'h650a7354; 6'd37: w = 32'h766a0abb;
            6'd38: w = 32'h81c2c92e; 6'd39: w = 32'h92722c85;
            6'd40: w = 32'ha2bfe8a1; 6'd41: w = 32'ha81a664b;
            6'd42: w = 32'hc24b8b70; 6'd43: w = 32'hc76c51a3;
            6'd44: w = 32'hd192e819; 6'd45: w = 32'hd6990624;
            6'd46: w = 32'hf40e3585; 6'd47: w = 32'h106aa070;
            6'd48: w = 32'h19a4c116; 6'd49: w = 32'h1e376c08;
            6'd50: w = 32'h2748774c; 6'd51: w = 32'h34b0bcb5;
            6'd52: w = 32'h391c0cb3; 6'd53: w = 32'h4ed8aa4a;
            6'd54: w = 32'h5b9cca4f; 6'd55: w = 32'h682e6ff3;
            6'd56: w = 32'h748f82ee; 6'd57: w = 32'h78a5636f;
            6'd58: w = 32'h84c87814; 6'd59: w = 32'h8cc70208;
            6'd60: w = 32'h90befffa; 6'd61: w = 32'ha4506ceb;
            6'd62: w = 32'hbef9a3f7; default: w = 32'hc67178f2;
        endcase
        return w;
    endfunction

    function automatic t_word big_s0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_s1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_s0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_s1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== design/sha_if.sv =====
// valid/ready channel interfaces for byte input items and digest word items
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;

    modport source (output valid, output data_byte, output last_byte, output no_data,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input no_data,
                    output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== design/sha_ctrl.sv =====
// controller state machine: byte intake, padding sequence, round count, digest handoff
module sha_ctrl
    import sha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    input  logic    i_no_data,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_LOAD, S_ROUND, S_ADD, S_DONE
    } t_state;

    // which compression of a message is running
    typedef enum logic [1:0] {
        P_MSG, P_PAD, P_FINAL
    } t_phase;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_WORDS * 4 - 1);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    t_state           r_state;
    t_phase           r_phase;
    logic             r_last;
    logic [RND_W-1:0] r_round;
    logic             w_acc;
    logic             w_len_fits;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc      = i_valid && o_ready;
    // length field fits behind the pad byte when the pad lands before byte 56
    assign w_len_fits = (i_sts.pos[POS_W-1:3] != 3'b111);

    // commands decoded from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.put_byte = w_acc && !i_no_data;
        o_cmd.pad      = (r_state == S_PAD);
        o_cmd.len      = (r_state == S_LEN);
        o_cmd.clr_all  = (r_state == S_LEN) && (r_phase == P_PAD);
        o_cmd.load_v   = (r_state == S_LOAD);
        o_cmd.round    = (r_state == S_ROUND);
        o_cmd.rnd      = r_round;
        o_cmd.add_hash = (r_state == S_ADD);
        o_cmd.finish   = (r_state == S_DONE) && !i_sts.out_busy;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_MSG;
            r_last  <= 1'b0;
            r_round <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_last  <= i_last;
                        r_phase <= P_MSG;
                        if (!i_no_data && i_sts.pos == POS_LAST) begin
                            r_state <= S_LOAD;
                        end else if (i_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (w_len_fits) begin
                        r_state <= S_LEN;
                    end else begin
                        r_phase <= P_PAD;
                        r_state <= S_LOAD;
                    end
                end
                S_LEN: begin
                    r_phase <= P_FINAL;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == RND_LAST) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    unique case (r_phase)
                        P_MSG:   r_state <= r_last ? S_PAD : S_IDLE;
                        P_PAD:   r_state <= S_LEN;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    if (!i_sts.out_busy) begin
                        r_last  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the last round always hands over to the hash update
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == RND_LAST) |=> (r_state == S_ADD))
        else $error("round counter did not end compression");

    // a digest never overwrites words still being delivered
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.out_busy)
        else $error("digest loaded while output busy");

    // bytes are taken only between compressions
    a_no_byte_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put_byte |-> !o_cmd.round && !o_cmd.pad && !o_cmd.len)
        else $error("byte written during block processing");

endmodule

// ===== design/sha_dp.sv =====
// datapath: block words, working variables, round logic, hash state, digest output buffer
module sha_dp
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HASH_WORDS - 1);

    t_word            r_hash [HASH_WORDS];
    t_word            r_blk  [BLOCK_WORDS];
    t_word            r_v    [HASH_WORDS];
    t_word            r_obuf [HASH_WORDS];
    logic [POS_W-1:0] r_pos;
    logic [LEN_W-1:0] r_bits;
    logic [IDX_W-1:0] r_oidx;
    logic             r_ovalid;

    logic [7:0]       w_byte;
    logic [3:0]       w_widx;
    t_word            w_lane_bits;
    t_word            w_wt;
    t_word            w_t1;
    t_word            w_t2;
    t_word            w_ch;
    t_word            w_maj;
    logic             w_out_take;

    assign o_sts.pos      = r_pos;
    assign o_sts.out_busy = r_ovalid;

    // byte lane placement, big-endian within a word
    assign w_byte      = i_cmd.pad ? PAD_BYTE : i_data_byte;
    assign w_widx      = r_pos[POS_W-1:2];
    assign w_lane_bits = {w_byte, 24'b0} >> {r_pos[1:0], 3'b000};

    // message schedule word and round sums
    assign w_wt  = (i_cmd.rnd[RND_W-1:4] != '0)
                 ? small_s1(r_blk[14]) + r_blk[9] + small_s0(r_blk[1]) + r_blk[0]
                 : r_blk[0];
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + big_s1(r_v[4]) + w_ch + k_word(i_cmd.rnd) + w_wt;
    assign w_t2  = big_s0(r_v[0]) + w_maj;

    assign w_out_take = r_ovalid && i_out_ready;

    // block words: byte writes, padding, length field and schedule window shift
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < BLOCK_WORDS; j++) begin
            if (i_cmd.round) begin
                r_blk[j] <= (j == BLOCK_WORDS - 1) ? w_wt : r_blk[(j + 1) % BLOCK_WORDS];
            end else if (i_cmd.put_byte || i_cmd.pad) begin
                if (w_widx == 4'(j)) begin
                    r_blk[j] <= (r_pos[1:0] == 2'b00) ? w_lane_bits : (r_blk[j] | w_lane_bits);
                end else if (i_cmd.pad && 4'(j) > w_widx) begin
                    r_blk[j] <= '0;
                end
            end else if (i_cmd.len) begin
                if (j == BLOCK_WORDS - 2) begin
                    r_blk[j] <= r_bits[LEN_W-1:WORD_W];
                end else if (j == BLOCK_WORDS - 1) begin
                    r_blk[j] <= r_bits[WORD_W-1:0];
                end else if (i_cmd.clr_all) begin
                    r_blk[j] <= '0;
                end
            end
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_v) begin
            for (int j = 0; j < HASH_WORDS; j++) begin
                r_v[j] <= r_hash[j];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // hash state, byte position and bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HASH_WORDS; j++) begin
                r_hash[j] <= iv_word(IDX_W'(j));
            end
            r_pos  <= '0;
            r_bits <= '0;
        end else if (i_cmd.finish) begin
            for (int j = 0; j < HASH_WORDS; j++) begin
                r_hash[j] <= iv_word(IDX_W'(j));
            end
            r_pos  <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.add_hash) begin
                for (int j = 0; j < HASH_WORDS; j++) begin
                    r_hash[j] <= r_hash[j] + r_v[j];
                end
            end
            if (i_cmd.put_byte) begin
                r_pos  <= r_pos + 1'b1;
                r_bits <= r_bits + LEN_W'(8);
            end
        end
    end

    // digest output buffer, shifted out one word per item
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int j = 0; j < HASH_WORDS; j++) begin
                r_obuf[j] <= r_hash[j];
            end
        end else if (w_out_take) begin
            for (int j = 0; j < HASH_WORDS; j++) begin
                r_obuf[j] <= r_obuf[(j + 1) % HASH_WORDS];
            end
        end
    end

    // output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
            r_oidx   <= '0;
        end else if (w_out_take) begin
            r_oidx <= r_oidx + 1'b1;
            if (r_oidx == IDX_LAST) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_digest_word = r_obuf[0];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == IDX_LAST);

    // a fresh digest starts at the most significant word
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_ovalid && r_oidx == '0))
        else $error("digest output did not restart at word zero");

    // delivery stops right after the final word
    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && o_last_word && !i_cmd.finish) |=> !r_ovalid)
        else $error("output kept running past the final word");

    // a new message starts at byte zero
    a_restart_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_pos == '0 && r_bits == '0))
        else $error("message state not cleared after digest");

endmodule

// ===== design/sha256_digest.sv =====
// sha-256 digest over a byte stream: top level joining controller and datapath
//
// Input channel i_in carries one message byte per item (data_byte), a flag
// marking the final item of the message (last_byte), and no_data, which makes
// the item carry no byte; no_data with last_byte digests the empty message.
// Output channel o_out gives the eight 32-bit digest words as eight items,
// word_index 0 (most significant) first, last_word set on word 7.
// A byte item is taken whenever the block is idle; every 64th byte starts a
// compression that holds the input (load, 64 rounds of the single round
// unit, hash update), so no byte is taken while a block is compressed.
// After the final item, padding and the length block hold the input (pad,
// length, then one compression; a second block when the pad byte falls at or
// beyond byte 56); the first digest word is offered when input ready returns.
// When the final byte completes a block, its compression runs first.
// The digest sits in its own output buffer, so the next message is taken
// while words still wait on a stalled receiver; only a following digest
// waits until the buffer has drained.
// Synchronous reset loads the initial hash value, clears the byte count and
// drops all output items.
module sha256_digest
    import sha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    assign i_in.ready = w_ready;

    // sequencing
    sha_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_last    (i_in.last_byte),
        .i_no_data (i_in.no_data),
        .o_ready   (w_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // storage and arithmetic
    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_data_byte   (i_in.data_byte),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_digest_word (o_out.digest_word),
        .o_word_index  (o_out.word_index),
        .o_last_word   (o_out.last_word)
    );

endmodule
